>>> src/deq_pkg.sv
// Shared types and codes for the double-ended queue.
package deq_pkg;

   localparam int WORD_W   = 32;
   localparam int OP_W     = 2;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INS_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_INS_BACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_REM_FRONT = 2'd2;
   localparam logic [OP_W-1:0] OP_REM_BACK  = 2'd3;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic signed [WORD_W-1:0] front_value;
      logic signed [WORD_W-1:0] back_value;
   } rsp_type;

   // Classified item passed from front part to back part
   typedef struct packed {
      logic                     insert;
      logic                     at_front;
      logic signed [WORD_W-1:0] value;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

endpackage

>>> src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> src/deq_front.sv
// Front part: accepts items, classifies the operation, queues them for the back part.
module deq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  deq_pkg::req_type  req_data,
   output logic              cmd_valid,
   output deq_pkg::cmd_type  cmd,
   input  logic              cmd_pop
);

   deq_pkg::cmd_type q_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push;
   deq_pkg::cmd_type cls;

   // Classify the incoming operation
   always_comb begin
      cls.insert   = (req_data.op == deq_pkg::OP_INS_FRONT) ||
                     (req_data.op == deq_pkg::OP_INS_BACK);
      cls.at_front = (req_data.op == deq_pkg::OP_INS_FRONT) ||
                     (req_data.op == deq_pkg::OP_REM_FRONT);
      cls.value    = req_data.value;
   end

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ptr_ff];

   // Queue pointers and fill
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, cmd_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Queue storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

>>> src/deq_back.sv
// Back part: ring buffer engine that carries out each operation and forms its result.
module deq_back #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  deq_pkg::cmd_type  cmd,
   output logic              cmd_pop,
   input  logic              slot_free,
   output logic              res_valid,
   output deq_pkg::rsp_type  res
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   deq_pkg::back_state_type state_ff, state_in;

   logic [IDX_W-1:0] front_idx_ff, front_idx_in;
   logic [IDX_W-1:0] back_idx_ff, back_idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             side_ff, side_in;
   logic signed [deq_pkg::WORD_W-1:0] front_val_ff, front_val_in;
   logic signed [deq_pkg::WORD_W-1:0] back_val_ff, back_val_in;

   logic             take;
   logic             empty;
   logic             full;
   logic             needs_read;
   logic [IDX_W-1:0] front_next, front_prev, back_next, back_prev;

   logic                       wr_en;
   logic [IDX_W-1:0]           wr_addr;
   logic                       rd_en;
   logic [IDX_W-1:0]           rd_addr;
   logic [deq_pkg::WORD_W-1:0] rd_data;

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (cmd.value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Ring index neighbors
   always_comb begin
      front_next = (front_idx_ff == IDX_LAST) ? '0 : front_idx_ff + IDX_W'(1);
      front_prev = (front_idx_ff == '0) ? IDX_LAST : front_idx_ff - IDX_W'(1);
      back_next  = (back_idx_ff == IDX_LAST) ? '0 : back_idx_ff + IDX_W'(1);
      back_prev  = (back_idx_ff == '0) ? IDX_LAST : back_idx_ff - IDX_W'(1);
   end

   assign empty      = (count_ff == '0);
   assign full       = (count_ff == CNT_FULL);
   assign take       = (state_ff == deq_pkg::BK_IDLE) && cmd_valid && slot_free;
   assign needs_read = !cmd.insert && (count_ff > CNT_W'(1));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (take && needs_read) begin
               state_in = deq_pkg::BK_READ;
            end
         end
         deq_pkg::BK_READ: begin
            state_in = deq_pkg::BK_IDLE;
         end
         default: begin
            state_in = deq_pkg::BK_IDLE;
         end
      endcase
   end

   // Datapath and outputs
   always_comb begin
      front_idx_in = front_idx_ff;
      back_idx_in  = back_idx_ff;
      count_in     = count_ff;
      side_in      = side_ff;
      front_val_in = front_val_ff;
      back_val_in  = back_val_ff;
      wr_en        = 1'b0;
      wr_addr      = front_idx_ff;
      rd_en        = 1'b0;
      rd_addr      = front_next;
      cmd_pop      = 1'b0;
      res_valid    = 1'b0;
      res.status   = deq_pkg::ST_DONE;
      unique case (state_ff)
         deq_pkg::BK_IDLE: begin
            if (take) begin
               cmd_pop = 1'b1;
               if (cmd.insert) begin
                  res_valid = 1'b1;
                  if (full) begin
                     res.status = deq_pkg::ST_FULL;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     wr_en    = 1'b1;
                     priority if (empty) begin
                        back_idx_in  = front_idx_ff;
                        wr_addr      = front_idx_ff;
                        front_val_in = cmd.value;
                        back_val_in  = cmd.value;
                     end else if (cmd.at_front) begin
                        front_idx_in = front_prev;
                        wr_addr      = front_prev;
                        front_val_in = cmd.value;
                     end else begin
                        back_idx_in = back_next;
                        wr_addr     = back_next;
                        back_val_in = cmd.value;
                     end
                  end
               end else if (empty) begin
                  res_valid  = 1'b1;
                  res.status = deq_pkg::ST_EMPTY;
               end else if (!needs_read) begin
                  // last entry leaves
                  res_valid = 1'b1;
                  count_in  = count_ff - CNT_W'(1);
               end else begin
                  // fetch the entry that becomes the new end
                  count_in = count_ff - CNT_W'(1);
                  side_in  = cmd.at_front;
                  rd_en    = 1'b1;
                  if (cmd.at_front) begin
                     front_idx_in = front_next;
                     rd_addr      = front_next;
                  end else begin
                     back_idx_in = back_prev;
                     rd_addr     = back_prev;
                  end
               end
            end
         end
         deq_pkg::BK_READ: begin
            res_valid = 1'b1;
            if (side_ff) begin
               front_val_in = rd_data;
            end else begin
               back_val_in = rd_data;
            end
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
      res.count       = deq_pkg::COUNT_W'(count_in);
      res.front_value = (count_in == '0) ? '0 : front_val_in;
      res.back_value  = (count_in == '0) ? '0 : back_val_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= deq_pkg::BK_IDLE;
         front_idx_ff <= '0;
         back_idx_ff  <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         front_idx_ff <= front_idx_in;
         back_idx_ff  <= back_idx_in;
         count_ff     <= count_in;
      end
   end

   // Cached end values and pending side, no reset needed
   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      front_val_ff <= front_val_in;
      back_val_ff  <= back_val_in;
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("entry count exceeds depth");

   a_read_one_cycle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == deq_pkg::BK_READ) |=> (state_ff == deq_pkg::BK_IDLE))
      else $error("read state held longer than one cycle");

   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> slot_free)
      else $error("result produced while output slot busy");

   a_empty_remove: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && !cmd.insert && empty) |-> (res.status == deq_pkg::ST_EMPTY))
      else $error("remove on empty deque not flagged");

endmodule

>>> src/double_ended_queue.sv
// An insert, or a remove that empties or finds the deque empty, passes the front queue and the
// output register to rsp_; a remove that leaves entries also passes BK_READ to read the new end.
// Throughput: one item per cycle while rsp_stall is low, except while BK_READ holds the engine.
// A 2-entry queue between the front and back parts lets the input and output stall apart.
// Reset (synchronous, active high) empties the deque and queues; RAM contents are not cleared.
module double_ended_queue #(
   parameter int DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  deq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output deq_pkg::rsp_type rsp_data
);

   logic             cmd_valid;
   deq_pkg::cmd_type cmd;
   logic             cmd_pop;
   logic             slot_free;
   logic             res_valid;
   deq_pkg::rsp_type res;

   logic             rsp_valid_ff, rsp_valid_in;
   deq_pkg::rsp_type rsp_ff;

   deq_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   deq_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .slot_free (slot_free),
      .res_valid (res_valid),
      .res       (res)
   );

   // Output register
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
